// ===== hdl/rcfed_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcfed_pkg;

  // Feedback image: one row per feedback module, sixteen inputs per module.
  localparam int FEEDBACK_INPUTS_DEF = 1024;
  localparam int FbRowBits = 16;

  // Command codes with the response bit in the lsb.
  localparam logic [7:0] CMD_FEEDBACK   = 8'h21;
  localparam logic [7:0] CMD_LOCO_DIR   = 8'h0A;
  localparam logic [7:0] CMD_LOCO_SPEED = 8'h08;
  localparam logic [7:0] CMD_FUNCTION   = 8'h0C;
  localparam logic [7:0] CMD_SWITCH     = 8'h16;

  localparam logic [7:0] FUNC_NUM_MAX = 8'd28;
  localparam logic [7:0] GATE_ON      = 8'h01;
  localparam logic [7:0] STATE_ONE    = 8'h01;

  typedef enum logic [2:0] {
    KIND_FEEDBACK   = 3'd0,
    KIND_LOCO_DIR   = 3'd1,
    KIND_LOCO_SPEED = 3'd2,
    KIND_FUNCTION   = 3'd3,
    KIND_SWITCH     = 3'd4
  } kind_t;

  // Deciding bytes of one received frame.
  typedef struct packed {
    logic [7:0] command;
    logic [7:0] addr_high;
    logic [7:0] addr_low;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
  } in_item_t;

  // Decoded frame handed to the event sequencer. For a feedback frame the
  // address holds the module base and the mask one bit per changed input.
  typedef struct packed {
    kind_t       kind;
    logic [11:0] address;
    logic [2:0]  port;
    logic [15:0] value;
    logic        flag;
    logic        fb;
    logic [15:0] bits;
    logic [15:0] mask;
  } ev_desc_t;

endpackage

`default_nettype wire

// ===== hdl/rcfed_fb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcfed_fb_store #(
  parameter int FEEDBACK_INPUTS = rcfed_pkg::FEEDBACK_INPUTS_DEF,
  localparam int ROWS  = FEEDBACK_INPUTS / rcfed_pkg::FbRowBits,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [ROW_W-1:0] rd_idx,
  input  wire logic             wr_en,
  input  wire logic [ROW_W-1:0] wr_idx,
  input  wire logic [15:0]      wr_data,
  output logic      [15:0]      old_row
);

  logic [15:0] mem [ROWS];
  logic [15:0] rd_data_r;
  logic        rd_vld_r;
  logic        byp_r;
  logic [15:0] byp_data_r;
  logic        row_vld_r [ROWS];

  // A row never written reads as all zeros, so reset only clears the
  // per-row valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        row_vld_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      row_vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // A write to the row being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= row_vld_r[rd_idx];
      byp_r    <= wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wr_data;
    end
  end

  always_comb begin
    if (byp_r) begin
      old_row = byp_data_r;
    end else if (rd_vld_r) begin
      old_row = rd_data_r;
    end else begin
      old_row = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rcfed_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcfed_classify #(
  parameter int FEEDBACK_INPUTS = rcfed_pkg::FEEDBACK_INPUTS_DEF,
  localparam int ROWS = FEEDBACK_INPUTS / rcfed_pkg::FbRowBits
) (
  input  wire rcfed_pkg::in_item_t item,
  input  wire logic [15:0]         old_row,
  output rcfed_pkg::ev_desc_t      desc,
  output logic                     fb_hit
);

  localparam logic [8:0] ROW_LIM = 9'(ROWS);

  logic [11:0] loco_addr;
  logic [2:0]  sw_hi;
  logic [10:0] sw_lin;
  logic [15:0] fb_new;

  assign loco_addr = {item.addr_high[3:0], item.addr_low};
  // Protocol nibble values above 7 fold back onto 0..7.
  assign sw_hi     = item.addr_high[2:0];
  assign sw_lin    = {sw_hi, item.addr_low};
  assign fb_new    = {item.data1, item.data2};
  assign fb_hit    = (item.command == rcfed_pkg::CMD_FEEDBACK)
                     && ({1'b0, item.data0} < ROW_LIM);

  always_comb begin
    desc         = '0;
    desc.kind    = rcfed_pkg::KIND_FEEDBACK;
    desc.address = loco_addr;
    case (item.command)
      rcfed_pkg::CMD_FEEDBACK: begin
        if (fb_hit) begin
          desc.fb      = 1'b1;
          desc.address = {item.data0, 4'b0000};
          desc.bits    = fb_new;
          desc.mask    = fb_new ^ old_row;
        end
      end
      rcfed_pkg::CMD_LOCO_DIR: begin
        desc.kind = rcfed_pkg::KIND_LOCO_DIR;
        desc.flag = (item.data0 == rcfed_pkg::STATE_ONE);
        desc.mask = 16'h0001;
      end
      rcfed_pkg::CMD_LOCO_SPEED: begin
        desc.kind  = rcfed_pkg::KIND_LOCO_SPEED;
        desc.value = {item.data0, item.data1};
        desc.mask  = 16'h0001;
      end
      rcfed_pkg::CMD_FUNCTION: begin
        desc.kind  = rcfed_pkg::KIND_FUNCTION;
        desc.value = {8'h00, item.data0};
        desc.flag  = (item.data1 != 8'h00);
        if (item.data0 <= rcfed_pkg::FUNC_NUM_MAX) begin
          desc.mask = 16'h0001;
        end
      end
      rcfed_pkg::CMD_SWITCH: begin
        desc.kind    = rcfed_pkg::KIND_SWITCH;
        desc.address = 12'({1'b0, sw_lin[10:2]} + 10'd1);
        desc.port    = {1'b0, sw_lin[1:0]} + 3'd1;
        desc.flag    = (item.data0 == rcfed_pkg::STATE_ONE);
        if (item.data1 == rcfed_pkg::GATE_ON) begin
          desc.mask = 16'h0001;
        end
      end
      default: begin
        desc.mask = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/rcfed_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcfed_emitter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                ld,
  input  wire rcfed_pkg::ev_desc_t desc,
  output logic                     ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_kind,
  output logic [11:0]              out_address,
  output logic [2:0]               out_port,
  output logic [15:0]              out_value,
  output logic                     out_flag,
  output logic                     out_last
);

  rcfed_pkg::ev_desc_t s2_desc_r;
  logic                s2_vld_r;
  logic                s2_vld_nxt;
  logic                out_vld_r;
  logic                out_free;
  logic                emit;
  logic [3:0]          pos;
  logic [15:0]         mask_clr;
  logic                is_last;
  logic [11:0]         ev_addr;
  logic                ev_flag;

  logic [2:0]  out_kind_r;
  logic [11:0] out_address_r;
  logic [2:0]  out_port_r;
  logic [15:0] out_value_r;
  logic        out_flag_r;
  logic        out_last_r;

  // Lowest pending input goes first.
  always_comb begin
    pos = '0;
    for (int i = 15; i >= 0; i--) begin
      if (s2_desc_r.mask[i]) begin
        pos = 4'(i);
      end
    end
  end

  assign mask_clr = s2_desc_r.mask & (s2_desc_r.mask - 16'd1);
  assign is_last  = (mask_clr == '0);
  assign out_free = !out_vld_r || !out_stall;
  assign emit     = s2_vld_r && out_free;
  assign ready    = !s2_vld_r || (emit && is_last);

  always_comb begin
    if (s2_desc_r.fb) begin
      ev_addr = s2_desc_r.address + {8'h00, pos} + 12'd1;
      ev_flag = s2_desc_r.bits[pos];
    end else begin
      ev_addr = s2_desc_r.address;
      ev_flag = s2_desc_r.flag;
    end
  end

  always_comb begin
    if (ld) begin
      s2_vld_nxt = 1'b1;
    end else if (emit && is_last) begin
      s2_vld_nxt = 1'b0;
    end else begin
      s2_vld_nxt = s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s2_vld_nxt;
      if (out_free) begin
        out_vld_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s2_desc_r <= desc;
    end else if (emit) begin
      s2_desc_r.mask <= mask_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r    <= s2_desc_r.kind;
      out_address_r <= ev_addr;
      out_port_r    <= s2_desc_r.port;
      out_value_r   <= s2_desc_r.value;
      out_flag_r    <= ev_flag;
      out_last_r    <= is_last;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_kind    = out_kind_r;
  assign out_address = out_address_r;
  assign out_port    = out_port_r;
  assign out_value   = out_value_r;
  assign out_flag    = out_flag_r;
  assign out_last    = out_last_r;

  // A frame is loaded only into an empty or finishing sequencer.
  a_ld_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> ready)
    else $error("sequencer loaded while busy");

  // A held frame always has at least one event left.
  a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_desc_r.mask != '0))
    else $error("sequencer holds a frame with no events");

  // Frames other than feedback give exactly one event.
  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && !s2_desc_r.fb) |-> $onehot(s2_desc_r.mask))
    else $error("non-feedback frame with several events");

endmodule

`default_nettype wire

// ===== hdl/rail_can_frame_event_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rail CAN frame event decoder. Each input item carries the deciding bytes
// of one received command frame; the block classifies it by command byte
// and sends out zero or more event items, the final one of a frame marked
// with out_last. Loco direction, loco speed, function (number up to 28) and
// gated switch frames give one event each; a feedback reply compares its
// sixteen inputs with the stored image of that module and gives one event
// per changed input, lowest input first, while updating the image. Frames
// with any other command, feedback modules beyond FEEDBACK_INPUTS/16 and
// replies that change nothing give no event. The block takes one item per
// cycle as long as each gives at most one event and the output is not
// stalled; a feedback reply occupies the event sequencer until all its
// changed inputs are sent, and input items stall behind it. From accept to
// the first event an item passes the input register with the image read,
// decode into the sequencer, then the output register. The feedback image
// is a memory of 16-bit rows, one per module, with a valid bit per row that
// reset clears, so it is ready at once after reset with no clearing pass.

module rail_can_frame_event_decoder_unit #(
  parameter int FEEDBACK_INPUTS = rcfed_pkg::FEEDBACK_INPUTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_command,
  input  wire logic [7:0]  in_addr_high,
  input  wire logic [7:0]  in_addr_low,
  input  wire logic [7:0]  in_data0,
  input  wire logic [7:0]  in_data1,
  input  wire logic [7:0]  in_data2,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [11:0]      out_address,
  output logic [2:0]       out_port,
  output logic [15:0]      out_value,
  output logic             out_flag,
  output logic             out_last
);

  localparam int ROWS  = FEEDBACK_INPUTS / rcfed_pkg::FbRowBits;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Input stage.
  rcfed_pkg::in_item_t s1_item_r;
  logic                s1_vld_r;
  logic                s1_vld_nxt;
  logic                in_acc;
  logic                s1_adv;

  // Decode and sequencer hand-off.
  rcfed_pkg::ev_desc_t desc;
  logic                fb_hit;
  logic [15:0]         old_row;
  logic                seq_ready;
  logic                seq_ld;
  logic                wr_en;

  // The input register moves on as soon as the sequencer can take its
  // frame, so a new item enters in the same cycle.
  assign s1_adv   = s1_vld_r && seq_ready;
  assign in_stall = s1_vld_r && !seq_ready;
  assign in_acc   = in_valid && !in_stall;
  assign seq_ld   = s1_adv && (desc.mask != '0);
  assign wr_en    = s1_adv && fb_hit;

  always_comb begin
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.command   <= in_command;
      s1_item_r.addr_high <= in_addr_high;
      s1_item_r.addr_low  <= in_addr_low;
      s1_item_r.data0     <= in_data0;
      s1_item_r.data1     <= in_data1;
      s1_item_r.data2     <= in_data2;
    end
  end

  // The module's row is read while the item is captured; the row of the
  // frame leaving the input register is written back at the same edge.
  rcfed_fb_store #(
    .FEEDBACK_INPUTS (FEEDBACK_INPUTS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_idx  (in_data0[ROW_W-1:0]),
    .wr_en   (wr_en),
    .wr_idx  (s1_item_r.data0[ROW_W-1:0]),
    .wr_data ({s1_item_r.data1, s1_item_r.data2}),
    .old_row (old_row)
  );

  rcfed_classify #(
    .FEEDBACK_INPUTS (FEEDBACK_INPUTS)
  ) u_classify (
    .item    (s1_item_r),
    .old_row (old_row),
    .desc    (desc),
    .fb_hit  (fb_hit)
  );

  // The sequencer hands out one event per cycle into the output register while the output is not stalled.
  rcfed_emitter u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld          (seq_ld),
    .desc        (desc),
    .ready       (seq_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_address (out_address),
    .out_port    (out_port),
    .out_value   (out_value),
    .out_flag    (out_flag),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire
